[rtl/slcan_pkg.sv]
package slcan_pkg;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] host_byte;
		logic       transmitted;
	} slcan_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  reply_byte;
		logic [28:0] frame_ident;
		logic        frame_extended;
		logic        frame_remote;
		logic [3:0]  frame_length;
		logic [63:0] frame_payload;
		logic        last;
	} slcan_out_t;

	localparam logic [2:0] MODE_BYTE  = 3'd0;
	localparam logic [2:0] MODE_TXDONE = 3'd1;
	localparam logic [2:0] MODE_BUSOFF = 3'd2;
	localparam logic [2:0] MODE_RXOVF = 3'd3;
	localparam logic [2:0] MODE_DISC  = 3'd4;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic [7:0] FLAG_RX_FULL = 8'h01;
	localparam logic [7:0] FLAG_TX_FULL = 8'h02;
	localparam logic [7:0] FLAG_BUS_ERR = 8'h80;

	// reply texts, 6 chars, first char in [47:40]
	localparam logic [47:0] TXT_VER  = {"V4200", CH_CR};
	localparam logic [47:0] TXT_HVER = {"v0100", CH_CR};
	localparam logic [47:0] TXT_SER  = {"NFC42", CH_CR};

	typedef enum logic [2:0] {
		CMD_NONE, CMD_CR, CMD_BEL, CMD_TEXT, CMD_FLAGS, CMD_FRAME
	} reply_cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic store;      // append byte
		logic clr_fill;   // line_fill := 0
		logic scan_start; // start walking line
		logic scan_step;  // consume one stored char
	} slcan_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic        full;
		logic        empty;
	} slcan_sts_t;

	function automatic logic [9:0] speed_kbps(input logic [3:0] code);
		case (code)
			4'd0: speed_kbps = 10'd10;
			4'd1: speed_kbps = 10'd20;
			4'd2: speed_kbps = 10'd50;
			4'd3: speed_kbps = 10'd100;
			4'd4: speed_kbps = 10'd125;
			4'd5: speed_kbps = 10'd250;
			4'd6: speed_kbps = 10'd500;
			4'd7: speed_kbps = 10'd800;
			4'd8: speed_kbps = 10'd1000;
			default: speed_kbps = 10'd0;
		endcase
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		// bit 4 set means not a hex digit
		if (c >= "0" && c <= "9") hex_val = {1'b0, 4'(c - "0")};
		else if (c >= "A" && c <= "F") hex_val = {1'b0, 4'(c - "A" + 8'd10)};
		else if (c >= "a" && c <= "f") hex_val = {1'b0, 4'(c - "a" + 8'd10)};
		else hex_val = 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		hex_char = (v < 4'd10) ? 8'("0" + 8'(v)) : 8'("A" + 8'(v) - 8'd10);
	endfunction

endpackage

[rtl/slcan_datapath.sv]
module slcan_datapath import slcan_pkg::*; #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slcan_ctl_t                       ctl,
	input  logic [7:0]                       wr_byte,
	output slcan_sts_t                       sts,
	output logic [$clog2(LINE_CAPACITY)-1:0] fill,
	output logic [7:0]                       rd_byte
);
	localparam int FW = $clog2(LINE_CAPACITY);
	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_ptr_q;

	always_ff @(posedge clk) begin
		if (ctl.store) mem[fill_q[AW-1:0]] <= wr_byte;
		if (ctl.scan_start) rd_byte <= mem[0];
		else if (ctl.scan_step) rd_byte <= mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ctl.clr_fill) fill_q <= '0;
			else if (ctl.store) fill_q <= fill_q + FW'(1);
			if (ctl.scan_start) rd_ptr_q <= FW'(1);
			else if (ctl.scan_step && rd_ptr_q < FW'(DEPTH - 1)) rd_ptr_q <= rd_ptr_q + FW'(1);
		end
	end

	assign fill = fill_q;
	assign sts.full = (fill_q >= FW'(DEPTH));
	assign sts.empty = (fill_q == '0);
endmodule

[rtl/slcan_ctrl.sv]
module slcan_ctrl import slcan_pkg::*; #(
	parameter int LINE_CAPACITY  = 32,
	parameter int TX_QUEUE_DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [9:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  slcan_in_t                        in_beat,
	output logic                             out_valid,
	input  logic                             out_stall,
	output slcan_out_t                       out_beat,
	output slcan_ctl_t                       ctl,
	input  slcan_sts_t                       sts,
	input  logic [$clog2(LINE_CAPACITY)-1:0] fill,
	input  logic [7:0]                       rd_byte
);
	localparam int FW = $clog2(LINE_CAPACITY);
	localparam int QW = $clog2(TX_QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_EXEC = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t        state_q;
	logic [9:0]    bitrate_q;
	logic          open_q, speed_ok_q, stamps_q;
	logic [7:0]    flags_q;
	logic [QW-1:0] outst_q;
	logic [FW-1:0] pos_q;
	logic [7:0]    c0_q, c1_q;
	logic          bad_q;
	logic [31:0]   id_q;
	logic [3:0]    dlc_q;
	logic [63:0]   pay_q;
	logic [3:0]    hi_nib_q;
	reply_cmd_t    cmd_q;
	logic [47:0]   txt_q;
	logic [2:0]    cnt_q;

	logic       is_frame, ext, rtr;
	logic [FW-1:0] idlen, minlen;
	logic [4:0] hv;
	slcan_out_t beat_d;

	assign ext = (c0_q == "T") || (c0_q == "R");
	assign rtr = (c0_q == "r") || (c0_q == "R");
	assign is_frame = (c0_q == "t") || (c0_q == "T") || (c0_q == "r") || (c0_q == "R");
	assign idlen = ext ? FW'(8) : FW'(3);
	assign minlen = idlen + FW'(2);
	assign hv = hex_val(rd_byte);
	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);

	always_comb begin
		ctl = '0;
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			if (in_beat.mode == MODE_BYTE) begin
				if (in_beat.host_byte == CH_CR) begin
					ctl.scan_start = 1'b1;
				end else if (in_beat.host_byte != CH_LF) begin
					if (sts.full) ctl.clr_fill = 1'b1;
					else ctl.store = 1'b1;
				end
			end else if (in_beat.mode == MODE_DISC) begin
				ctl.clr_fill = 1'b1;
			end
		end
		if (state_q == ST_RD || state_q == ST_SCAN) ctl.scan_step = 1'b1;
		if (state_q == ST_EXEC) ctl.clr_fill = 1'b1;
	end

	always_comb begin
		beat_d = '0;
		case (cmd_q)
			CMD_TEXT: begin
				beat_d.reply_byte = txt_q[47:40];
				beat_d.last = (cnt_q == 3'd1);
			end
			CMD_FRAME: begin
				beat_d.kind = 1'b1;
				beat_d.frame_ident = id_q[28:0];
				beat_d.frame_extended = ext;
				beat_d.frame_remote = rtr;
				beat_d.frame_length = dlc_q;
				beat_d.frame_payload = rtr ? 64'd0 : pay_q;
			end
			CMD_CR: begin
				beat_d.reply_byte = CH_CR;
				beat_d.last = 1'b1;
			end
			default: begin
				beat_d.reply_byte = CH_BEL;
				beat_d.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bitrate_q <= 10'd500;
			open_q <= 1'b0;
			speed_ok_q <= 1'b0;
			stamps_q <= 1'b0;
			flags_q <= '0;
			outst_q <= '0;
			out_valid <= 1'b0;
			out_beat <= '0;
			cnt_q <= '0;
			cmd_q <= CMD_NONE;
		end else begin
			if (cfg_we) bitrate_q <= cfg_data;
			if (out_valid && !out_stall && state_q != ST_EMIT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						case (in_beat.mode)
							MODE_BYTE: begin
								if (in_beat.host_byte == CH_CR) begin
									if (sts.empty) begin
										cmd_q <= CMD_CR;
										state_q <= ST_EMIT;
									end else begin
										state_q <= ST_RD;
									end
								end else if (in_beat.host_byte != CH_LF && sts.full) begin
									cmd_q <= CMD_BEL;
									state_q <= ST_EMIT;
								end
							end
							MODE_TXDONE: begin
								if (outst_q != '0) begin
									outst_q <= outst_q - QW'(1);
									if (!in_beat.transmitted) flags_q <= flags_q | FLAG_BUS_ERR;
								end
							end
							MODE_BUSOFF: flags_q <= flags_q | FLAG_BUS_ERR;
							MODE_RXOVF: if (open_q) flags_q <= flags_q | FLAG_RX_FULL;
							default: ;
						endcase
					end
				end
				ST_RD: begin
					c0_q <= rd_byte;
					pos_q <= FW'(1);
					bad_q <= 1'b0;
					id_q <= '0;
					dlc_q <= '0;
					pay_q <= '0;
					state_q <= (fill == FW'(1)) ? ST_EXEC : ST_SCAN;
				end
				ST_SCAN: begin
					if (pos_q == FW'(1)) c1_q <= rd_byte;
					if (is_frame) begin
						if (pos_q <= idlen) begin
							if (hv[4]) bad_q <= 1'b1;
							id_q <= {id_q[27:0], hv[3:0]};
						end else if (pos_q == idlen + FW'(1)) begin
							if (hv[4]) bad_q <= 1'b1;
							dlc_q <= hv[3:0];
						end else begin
							if (hv[4]) bad_q <= 1'b1;
							if (((pos_q - minlen) & FW'(1)) == '0) hi_nib_q <= hv[3:0];
							else pay_q <= pay_q |
								(64'({hi_nib_q, hv[3:0]}) << {(pos_q - minlen) >> 1, 3'b000});
						end
					end
					pos_q <= pos_q + FW'(1);
					if (pos_q + FW'(1) == fill) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_EMIT;
					case (c0_q)
						"C": if (fill == FW'(1) && open_q) begin
							open_q <= 1'b0;
							outst_q <= '0;
							cmd_q <= CMD_CR;
						end else cmd_q <= CMD_BEL;
						"S": if (fill == FW'(2) && !open_q && c1_q >= "0" && c1_q <= "8"
							&& speed_kbps(4'(c1_q - "0")) == bitrate_q) begin
							speed_ok_q <= 1'b1;
							cmd_q <= CMD_CR;
						end else cmd_q <= CMD_BEL;
						"O": if (fill == FW'(1) && !open_q && speed_ok_q) begin
							open_q <= 1'b1;
							cmd_q <= CMD_CR;
						end else cmd_q <= CMD_BEL;
						"Z": if (fill == FW'(2) && !open_q && (c1_q == "0" || c1_q == "1")) begin
							stamps_q <= (c1_q == "1");
							cmd_q <= CMD_CR;
						end else cmd_q <= CMD_BEL;
						"F": if (fill == FW'(1) && open_q) begin
							txt_q <= {"F", hex_char(flags_q[7:4]), hex_char(flags_q[3:0]),
								CH_CR, 16'h0};
							flags_q <= '0;
							cmd_q <= CMD_TEXT;
							cnt_q <= 3'd4;
						end else cmd_q <= CMD_BEL;
						"V": if (fill == FW'(1)) begin
							txt_q <= TXT_VER; cmd_q <= CMD_TEXT; cnt_q <= 3'd6;
						end else cmd_q <= CMD_BEL;
						"v": if (fill == FW'(1)) begin
							txt_q <= TXT_HVER; cmd_q <= CMD_TEXT; cnt_q <= 3'd6;
						end else cmd_q <= CMD_BEL;
						"N": if (fill == FW'(1)) begin
							txt_q <= TXT_SER; cmd_q <= CMD_TEXT; cnt_q <= 3'd6;
						end else cmd_q <= CMD_BEL;
						"t", "T", "r", "R": begin
							if (open_q && fill >= minlen && !bad_q && dlc_q <= 4'd8
								&& id_q <= (ext ? 32'h1FFFFFFF : 32'h7FF)
								&& 6'(fill) == 6'(minlen) + (rtr ? 6'd0 : {1'b0, dlc_q, 1'b0}))
							begin
								if (outst_q >= QW'(TX_QUEUE_DEPTH)) begin
									flags_q <= flags_q | FLAG_TX_FULL;
									cmd_q <= CMD_BEL;
								end else begin
									outst_q <= outst_q + QW'(1);
									cmd_q <= CMD_FRAME;
								end
							end else cmd_q <= CMD_BEL;
						end
						default: cmd_q <= CMD_BEL;
					endcase
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_beat <= beat_d;
						case (cmd_q)
							CMD_TEXT: begin
								txt_q <= {txt_q[39:0], 8'h00};
								cnt_q <= cnt_q - 3'd1;
								if (cnt_q == 3'd1) state_q <= ST_IDLE;
							end
							CMD_FRAME: cmd_q <= CMD_CR;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/slcan_command_line_parser.sv]
// SLCAN command line parser.
// Input channel (in_valid/in_stall/in_beat) carries host bytes and link
// events; output channel (out_valid/out_stall/out_beat) carries reply bytes
// and decoded CAN frames, "last" marking the final beat of one input.
// cfg_we/cfg_data set the live bitrate in kbps (500 after reset).
// A CR walks the stored line one char per cycle through the line memory
// port (states ST_RD, ST_SCAN, ST_EXEC); ST_EMIT then sends the result
// one beat per cycle (up to 6) while out_stall is low.
// The block works on one item at a time; in_stall is high while a line is
// executed or results are pending.
// A stalled output holds its beat; the block waits until it is taken.
// arst_n clears line fill, channel state, flags and the frame counter.
module slcan_command_line_parser import slcan_pkg::*; #(
	parameter int LINE_CAPACITY  = 32,
	parameter int TX_QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  slcan_in_t  in_beat,
	output logic       out_valid,
	input  logic       out_stall,
	output slcan_out_t out_beat
);
	slcan_ctl_t ctl;
	slcan_sts_t sts;
	logic [$clog2(LINE_CAPACITY)-1:0] fill;
	logic [7:0] rd_byte;

	slcan_ctrl #(.LINE_CAPACITY(LINE_CAPACITY), .TX_QUEUE_DEPTH(TX_QUEUE_DEPTH)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_valid, .in_stall, .in_beat,
		.out_valid, .out_stall, .out_beat, .ctl, .sts, .fill, .rd_byte
	);

	slcan_datapath #(.LINE_CAPACITY(LINE_CAPACITY)) u_dp (
		.clk, .arst_n, .ctl, .wr_byte(in_beat.host_byte), .sts, .fill, .rd_byte
	);
endmodule
